// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising clock edge.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold on a rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/vuri_pkg.sv
// ----------------------------------------------------------------------------
// vuri_pkg
// Types and constants shared by the video unit register interface modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vuri_pkg;

	localparam int SPRITE_BYTES = 256;

	localparam logic [13:0] PALETTE_BASE = 14'h3F00;
	localparam logic [7:0]  STATUS_RESET = 8'h10;
	localparam int          VBL_BIT      = 7;
	localparam int          INC_BIT      = 2;

	typedef enum logic [2:0] {
		OP_READ      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_VBL_START = 3'd2,
		OP_VBL_END   = 3'd3,
		OP_DMA       = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_CTRL     = 3'd0,
		REG_MASK     = 3'd1,
		REG_STATUS   = 3'd2,
		REG_SPR_ADDR = 3'd3,
		REG_SPR_DATA = 3'd4,
		REG_SCROLL   = 3'd5,
		REG_ADDR     = 3'd6,
		REG_DATA     = 3'd7
	} reg_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [2:0] reg_select;
		logic [7:0] write_data;
		logic [7:0] vram_read_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        nmi_pulse;
		logic        vram_write_enable;
		logic [13:0] vram_write_addr;
		logic [7:0]  vram_write_data;
		logic [13:0] next_read_addr;
		logic [14:0] temp_addr_out;
		logic [2:0]  fine_scroll;
		logic [7:0]  control_out;
		logic [7:0]  mask_out;
		logic        vblank_level;
	} result_t;

	typedef struct packed {
		logic       we;
		logic [7:0] ptr;
		logic [7:0] wdata;
	} spr_req_t;

endpackage

`default_nettype wire

// File: rtl/vuri_sprite_mem.sv
// ----------------------------------------------------------------------------
// vuri_sprite_mem
// Sprite table: single-port-write, registered-read memory. Per-entry valid
// bits make entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vuri_sprite_mem #(
	parameter int DEPTH = vuri_pkg::SPRITE_BYTES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rdata_s1;
	logic             rvalid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_s1 <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_s1 ? rdata_s1 : 8'h00;

endmodule

`default_nettype wire

// File: rtl/vuri_core.sv
// ----------------------------------------------------------------------------
// vuri_core
// Register state of the interface: control, mask, status, scroll addresses,
// write toggle and read buffer. Computes the result of one item and commits
// the new state on the execute strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module vuri_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              exec,
	input  wire vuri_pkg::item_t   item,
	input  wire logic [7:0]        spr_rdata,
	output vuri_pkg::result_t      result,
	output vuri_pkg::spr_req_t     spr_req
);

	logic [7:0]  ctrl_q, ctrl_n;
	logic [7:0]  mask_q, mask_n;
	logic [7:0]  status_q, status_n;
	logic [7:0]  ptr_q, ptr_n;
	logic [14:0] cur_q, cur_n;
	logic [14:0] temp_q, temp_n;
	logic [2:0]  fine_x_q, fine_x_n;
	logic        toggle_q, toggle_n;
	logic [7:0]  rbuf_q, rbuf_n;
	logic        vbl_q, vbl_n;

	logic [7:0]  rdata;
	logic        nmi;
	logic        vwe;
	logic        spr_we;
	logic [14:0] step;
	logic [7:0]  wd;

	assign wd   = item.write_data;
	assign step = ctrl_q[vuri_pkg::INC_BIT] ? 15'd32 : 15'd1;

	always_comb begin
		ctrl_n   = ctrl_q;
		mask_n   = mask_q;
		status_n = status_q;
		ptr_n    = ptr_q;
		cur_n    = cur_q;
		temp_n   = temp_q;
		fine_x_n = fine_x_q;
		toggle_n = toggle_q;
		rbuf_n   = rbuf_q;
		vbl_n    = vbl_q;
		rdata    = 8'h00;
		nmi      = 1'b0;
		vwe      = 1'b0;
		spr_we   = 1'b0;

		case (vuri_pkg::op_t'(item.opcode))
			vuri_pkg::OP_READ: begin
				case (vuri_pkg::reg_t'(item.reg_select))
					vuri_pkg::REG_STATUS: begin
						rdata                       = status_q;
						status_n[vuri_pkg::VBL_BIT] = 1'b0;
						toggle_n                    = 1'b0;
					end
					vuri_pkg::REG_SPR_DATA: begin
						rdata = spr_rdata;
					end
					vuri_pkg::REG_DATA: begin
						if (cur_q[13:0] < vuri_pkg::PALETTE_BASE) begin
							rdata  = rbuf_q;
							rbuf_n = item.vram_read_data;
						end else begin
							rdata = item.vram_read_data;
						end
						cur_n = cur_q + step;
					end
					default: begin
					end
				endcase
			end
			vuri_pkg::OP_WRITE: begin
				case (vuri_pkg::reg_t'(item.reg_select))
					vuri_pkg::REG_CTRL: begin
						ctrl_n        = wd;
						temp_n[11:10] = wd[1:0];
						nmi = !ctrl_q[vuri_pkg::VBL_BIT] && wd[vuri_pkg::VBL_BIT]
							&& status_q[vuri_pkg::VBL_BIT];
					end
					vuri_pkg::REG_MASK: begin
						mask_n = wd;
					end
					vuri_pkg::REG_SPR_ADDR: begin
						ptr_n = wd;
					end
					vuri_pkg::REG_SPR_DATA: begin
						spr_we = 1'b1;
						ptr_n  = ptr_q + 8'd1;
					end
					vuri_pkg::REG_SCROLL: begin
						if (!toggle_q) begin
							fine_x_n    = wd[2:0];
							temp_n[4:0] = wd[7:3];
							toggle_n    = 1'b1;
						end else begin
							temp_n[14:12] = wd[2:0];
							temp_n[9:5]   = wd[7:3];
							toggle_n      = 1'b0;
						end
					end
					vuri_pkg::REG_ADDR: begin
						if (!toggle_q) begin
							temp_n   = {1'b0, wd[5:0], temp_q[7:0]};
							toggle_n = 1'b1;
						end else begin
							temp_n   = {temp_q[14:8], wd};
							cur_n    = {temp_q[14:8], wd};
							toggle_n = 1'b0;
						end
					end
					vuri_pkg::REG_DATA: begin
						vwe   = 1'b1;
						cur_n = cur_q + step;
					end
					default: begin
					end
				endcase
			end
			vuri_pkg::OP_VBL_START: begin
				vbl_n = 1'b1;
				if (!status_q[vuri_pkg::VBL_BIT]) begin
					status_n[vuri_pkg::VBL_BIT] = 1'b1;
					nmi = ctrl_q[vuri_pkg::VBL_BIT];
				end
			end
			vuri_pkg::OP_VBL_END: begin
				vbl_n                       = 1'b0;
				status_n[vuri_pkg::VBL_BIT] = 1'b0;
			end
			vuri_pkg::OP_DMA: begin
				spr_we = 1'b1;
				ptr_n  = ptr_q + 8'd1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.read_data         = rdata;
		result.nmi_pulse         = nmi;
		result.vram_write_enable = vwe;
		result.vram_write_addr   = vwe ? cur_q[13:0] : 14'd0;
		result.vram_write_data   = vwe ? wd : 8'h00;
		result.next_read_addr    = cur_n[13:0];
		result.temp_addr_out     = temp_n;
		result.fine_scroll       = fine_x_n;
		result.control_out       = ctrl_n;
		result.mask_out          = mask_n;
		result.vblank_level      = vbl_n;
	end

	// Sprite write lands at the pointer held before this item.
	assign spr_req.we    = exec && spr_we;
	assign spr_req.ptr   = ptr_q;
	assign spr_req.wdata = wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= 8'h00;
			mask_q   <= 8'h00;
			status_q <= vuri_pkg::STATUS_RESET;
			ptr_q    <= 8'h00;
			cur_q    <= 15'd0;
			temp_q   <= 15'd0;
			fine_x_q <= 3'd0;
			toggle_q <= 1'b0;
			rbuf_q   <= 8'h00;
			vbl_q    <= 1'b0;
		end else if (exec) begin
			ctrl_q   <= ctrl_n;
			mask_q   <= mask_n;
			status_q <= status_n;
			ptr_q    <= ptr_n;
			cur_q    <= cur_n;
			temp_q   <= temp_n;
			fine_x_q <= fine_x_n;
			toggle_q <= toggle_n;
			rbuf_q   <= rbuf_n;
			vbl_q    <= vbl_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/video_unit_register_interface.sv
// ----------------------------------------------------------------------------
// video_unit_register_interface
// CPU-facing register block of a tile video unit: register reads and
// writes, vblank events and sprite DMA bytes, one result per item.
// ----------------------------------------------------------------------------
//
//   channel   handshake         payload
//   -------   ---------------   ---------------------------------------------
//   item      start / busy      opcode, reg_select, write_data, vram_read_data
//   result    done (strobe)     read_data ... vblank_level, one cycle only
//
// The accept edge of an item issues the sprite table read at
// the current pointer, and the following edge commits the register and
// sprite table updates and loads the result registers. busy is high for the
// one cycle between those edges; done follows for one cycle, during which
// the next item may already be accepted. After reset the block is idle, all
// state at its reset values and the sprite table reads as zero. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module video_unit_register_interface #(
	parameter int SPRITE_BYTES = vuri_pkg::SPRITE_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [2:0]  reg_select,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  vram_read_data,
	output logic             done,
	output logic [7:0]       read_data,
	output logic             nmi_pulse,
	output logic             vram_write_enable,
	output logic [13:0]      vram_write_addr,
	output logic [7:0]       vram_write_data,
	output logic [13:0]      next_read_addr,
	output logic [14:0]      temp_addr_out,
	output logic [2:0]       fine_scroll,
	output logic [7:0]       control_out,
	output logic [7:0]       mask_out,
	output logic             vblank_level
);

	localparam int AW = $clog2(SPRITE_BYTES);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t              state_q;
	logic                done_q;
	vuri_pkg::item_t     item_s1;
	vuri_pkg::result_t   res_q;
	vuri_pkg::result_t   res;
	vuri_pkg::spr_req_t  spr_req;
	logic [7:0]          spr_rdata;
	logic                accept;
	logic                exec;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;
	assign exec   = (state_q == ST_EXEC);

	vuri_sprite_mem #(
		.DEPTH(SPRITE_BYTES)
	) u_sprite_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept),
		.raddr  (spr_req.ptr[AW-1:0]),
		.rdata  (spr_rdata),
		.we     (spr_req.we),
		.waddr  (spr_req.ptr[AW-1:0]),
		.wdata  (spr_req.wdata)
	);

	vuri_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.exec      (exec),
		.item      (item_s1),
		.spr_rdata (spr_rdata),
		.result    (res),
		.spr_req   (spr_req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			item_s1 <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						item_s1 <= {opcode, reg_select, write_data, vram_read_data};
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// commit the item and present its result for one cycle
					res_q   <= res;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign read_data         = res_q.read_data;
	assign nmi_pulse         = res_q.nmi_pulse;
	assign vram_write_enable = res_q.vram_write_enable;
	assign vram_write_addr   = res_q.vram_write_addr;
	assign vram_write_data   = res_q.vram_write_data;
	assign next_read_addr    = res_q.next_read_addr;
	assign temp_addr_out     = res_q.temp_addr_out;
	assign fine_scroll       = res_q.fine_scroll;
	assign control_out       = res_q.control_out;
	assign mask_out          = res_q.mask_out;
	assign vblank_level      = res_q.vblank_level;

	`ASSERT_CLK(a_accept_exec, clk, arst_n, accept |=> busy, "accepted item did not execute")
	`ASSERT_CLK(a_exec_done, clk, arst_n, busy |=> (done && !busy), "execute without result strobe")
	`ASSERT_NEVER(a_done_busy, clk, arst_n, done && busy, "result strobe while busy")
	`ASSERT_CLK(a_done_origin, clk, arst_n, done |-> $past(busy), "result strobe without an item")

endmodule

`default_nettype wire
